// ----- design/skt_pkg.sv -----
`default_nettype none

package skt_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int STATUS_W  = 3;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_DUP     = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_MISSING = 3'd3,
		STAT_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_UPD  = 2'b10
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

endpackage

`default_nettype wire

// ----- design/sorted_key_table_top.sv -----
// Channel   Direction  Handshake                  Payload
// request   in         start && !busy            kind, key
// result    out        done (one cycle, no stall) status, position, entry_count
//
// Each request has a transfer cycle that compares the key against every cell
// at once and a following cycle that shifts the cells and updates the count.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset clears the entry count and controller; cell contents stay undefined.
// The receiver cannot stall: each result is valid for the single done cycle.
`default_nettype none

module sorted_key_table_top
	import skt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              kind,
	input  wire logic signed [KEY_W-1:0] key,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	output logic [CW-1:0]                position,
	output logic [CW-1:0]                entry_count
);

	cmd_t cmd;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	skt_datapath #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.key         (key),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

// ----- design/skt_ctrl.sv -----
`default_nettype none

module skt_ctrl
	import skt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output cmd_t      cmd
);

	fsm_t state_q;
	logic done_q;

	assign busy        = (state_q == FSM_UPD);
	assign cmd.capture = start && !busy;
	assign cmd.update  = busy;
	assign done        = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update;
			case (state_q)
				FSM_IDLE: begin
					if (cmd.capture) state_q <= FSM_UPD;
				end
				FSM_UPD: begin
					state_q <= FSM_IDLE;
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	a_upd_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("update stage held longer than one cycle");

	a_capture_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> busy) else $error("transfer accepted without update");

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done) else $error("update gave no result strobe");

	a_done_only_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while still updating");

endmodule

`default_nettype wire

// ----- design/skt_datapath.sv -----
`default_nettype none

module skt_datapath
	import skt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	input  wire logic [1:0]              kind,
	input  wire logic signed [KEY_W-1:0] key,
	output logic [STATUS_W-1:0]          status,
	output logic [CW-1:0]                position,
	output logic [CW-1:0]                entry_count
);

	logic signed [KEY_W-1:0] cell_q [DEPTH];
	logic signed [KEY_W-1:0] up_src [DEPTH];
	logic signed [KEY_W-1:0] dn_src [DEPTH];
	logic [DEPTH-1:0]        lt_s1;
	logic [DEPTH-1:0]        eq_s1;
	logic [DEPTH-1:0]        lb_oh;
	logic [DEPTH-1:0]        lt_now;
	logic [DEPTH-1:0]        eq_now;
	logic signed [KEY_W-1:0] req_q;
	kind_t                   kind_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_d;
	logic [CW-1:0]           idx;
	status_t                 status_d;
	logic [CW-1:0]           pos_d;
	status_t                 status_q;
	logic [CW-1:0]           pos_q;
	logic                    hit;
	logic                    full;
	logic                    empty;
	logic                    do_ins;
	logic                    do_del;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic cell_valid;
		assign cell_valid = (CW'(j) < count_q);
		assign lt_now[j]  = cell_valid && (cell_q[j] < key);
		assign eq_now[j]  = cell_valid && (cell_q[j] == key);

		if (j == 0) begin : g_first
			assign up_src[j] = req_q;
			assign lb_oh[j]  = !lt_s1[j];
		end else begin : g_rest
			assign up_src[j] = cell_q[j-1];
			assign lb_oh[j]  = !lt_s1[j] && lt_s1[j-1];
		end

		if (j == DEPTH - 1) begin : g_last
			assign dn_src[j] = cell_q[j];
		end else begin : g_inner
			assign dn_src[j] = cell_q[j+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				if (do_ins) begin
					if (lb_oh[j]) cell_q[j] <= req_q;
					else if (!lt_s1[j]) cell_q[j] <= up_src[j];
				end else if (do_del && !lt_s1[j]) begin
					cell_q[j] <= dn_src[j];
				end
			end
		end
	end

	always_comb begin
		idx = lt_s1[DEPTH-1] ? CW'(DEPTH) : '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lb_oh[i]) idx = idx | CW'(i);
		end
	end

	assign hit   = |eq_s1;
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		status_d = STAT_OK;
		pos_d    = '0;
		count_d  = count_q;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		case (kind_q)
			KIND_INSERT: begin
				if (hit) begin
					status_d = STAT_DUP;
					pos_d    = idx + CW'(1);
				end else if (full) begin
					status_d = STAT_FULL;
				end else begin
					pos_d   = idx + CW'(1);
					count_d = count_q + CW'(1);
					do_ins  = 1'b1;
				end
			end
			KIND_DELETE, KIND_SEARCH: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else if (!hit) begin
					status_d = STAT_MISSING;
				end else begin
					pos_d = idx + CW'(1);
					if (kind_q == KIND_DELETE) begin
						count_d = count_q - CW'(1);
						do_del  = 1'b1;
					end
				end
			end
			KIND_CLEAR: begin
				if (empty) status_d = STAT_EMPTY;
				count_d = '0;
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= key;
			kind_q <= kind_t'(kind);
			lt_s1  <= lt_now;
			eq_s1  <= eq_now;
		end
		if (cmd.update) begin
			status_q <= status_d;
			pos_q    <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			count_q <= count_d;
		end
	end

	assign status      = status_q;
	assign position    = pos_q;
	assign entry_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("entry count beyond table depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> $stable(count_q)) else $error("entry count moved outside update");

endmodule

`default_nettype wire
